>>> rtl/wptm_pkg.sv
// ============================================================================
// wptm_pkg
// Shared types and constants of the weighted patch top-k matcher.
// ============================================================================
`default_nettype none

package wptm_pkg;

    localparam int PIX_W    = 8;
    localparam int DIFF_W   = 10;
    localparam int WEIGHT_W = 12;
    localparam int COORD_W  = 10;
    localparam int DIST_W   = 17;
    localparam int PATCH_W  = 32;
    localparam int CENTER_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [DIST_W-1:0] EMPTY_DIST = DIST_W'(99999);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RING0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RING1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RING2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RING3 = 3'd5;

    typedef struct packed {
        logic               filled;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIST_W-1:0]  distance;
    } t_slot;

    localparam t_slot SLOT_EMPTY = '{filled: 1'b0, row: '0, col: '0, distance: EMPTY_DIST};

    // Commands broadcast to every slot cell
    typedef struct packed {
        logic  write;
        logic  shift;
        logic  clear;
        t_slot data;
    } t_cell_ctrl;

    // Status of the item held in the front stage
    typedef struct packed {
        logic valid;
        logic cand_end;
        logic query_end;
    } t_acc_status;

endpackage

`default_nettype wire

>>> rtl/wptm_acc.sv
// ============================================================================
// wptm_acc
// Two-stage front end: difference and weight pick, then saturating sums.
// ============================================================================
`default_nettype none

module wptm_acc #(
    parameter int MAX_RING    = 3,
    parameter int COORD_LIMIT = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_load,
    input  wire logic [wptm_pkg::PIX_W-1:0]              i_query_red,
    input  wire logic [wptm_pkg::PIX_W-1:0]              i_query_green,
    input  wire logic [wptm_pkg::PIX_W-1:0]              i_query_blue,
    input  wire logic [wptm_pkg::PIX_W-1:0]              i_cand_red,
    input  wire logic [wptm_pkg::PIX_W-1:0]              i_cand_green,
    input  wire logic [wptm_pkg::PIX_W-1:0]              i_cand_blue,
    input  wire logic [1:0]                              i_ring,
    input  wire logic [wptm_pkg::COORD_W-1:0]            i_cand_row,
    input  wire logic [wptm_pkg::COORD_W-1:0]            i_cand_col,
    input  wire logic                                    i_pixel_valid,
    input  wire logic                                    i_last_of_candidate,
    input  wire logic                                    i_last_of_query,
    input  wire logic [3:0][wptm_pkg::WEIGHT_W-1:0]      i_weights,
    input  wire logic                                    i_clear_sums,
    output wptm_pkg::t_acc_status                        o_status,
    output logic [wptm_pkg::COORD_W-1:0]                 o_row,
    output logic [wptm_pkg::COORD_W-1:0]                 o_col,
    output logic [wptm_pkg::PATCH_W-1:0]                 o_patch_sum,
    output logic [wptm_pkg::CENTER_W-1:0]                o_center_sum
);
    import wptm_pkg::*;

    localparam int        COORD_TOP = (COORD_LIMIT < 1024) ? COORD_LIMIT - 1 : 1023;
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_TOP);
    localparam logic [2:0] RING_MAX = 3'(MAX_RING);

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    logic                  r_s1_valid;
    logic                  r_s1_add;
    logic                  r_s1_center;
    logic [DIFF_W-1:0]     r_s1_diff;
    logic [WEIGHT_W-1:0]   r_s1_weight;
    logic                  r_s1_cand_end;
    logic                  r_s1_query_end;
    logic [COORD_W-1:0]    r_s1_row;
    logic [COORD_W-1:0]    r_s1_col;
    logic [PATCH_W-1:0]    r_patch_sum;
    logic [CENTER_W-1:0]   r_center_sum;

    logic [DIFF_W-1:0]     n_diff;
    logic                  n_add;
    logic [2*DIFF_W+1:0]   w_prod;
    logic [PATCH_W:0]      w_patch_ext;
    logic [CENTER_W:0]     w_center_ext;
    logic [PATCH_W-1:0]    n_patch_sum;
    logic [CENTER_W-1:0]   n_center_sum;

    assign n_diff = DIFF_W'(abs_diff(i_query_red, i_cand_red))
                  + DIFF_W'(abs_diff(i_query_green, i_cand_green))
                  + DIFF_W'(abs_diff(i_query_blue, i_cand_blue));
    assign n_add  = i_pixel_valid && ({1'b0, i_ring} <= RING_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_load;
        end
    end

    // Payload of the front stage: hold between loads
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_add       <= n_add;
            r_s1_center    <= (i_ring == 2'd0);
            r_s1_diff      <= n_diff;
            r_s1_weight    <= i_weights[i_ring];
            r_s1_cand_end  <= i_last_of_candidate;
            r_s1_query_end <= i_last_of_query;
            r_s1_row       <= (i_cand_row > COORD_MAX) ? COORD_MAX : i_cand_row;
            r_s1_col       <= (i_cand_col > COORD_MAX) ? COORD_MAX : i_cand_col;
        end
    end

    assign w_prod       = r_s1_diff * r_s1_weight;
    assign w_patch_ext  = {1'b0, r_patch_sum} + (PATCH_W + 1)'(w_prod);
    assign w_center_ext = {1'b0, r_center_sum} + {1'b0, r_s1_diff};

    always_comb begin
        n_patch_sum  = r_patch_sum;
        n_center_sum = r_center_sum;
        if (i_clear_sums) begin
            n_patch_sum  = '0;
            n_center_sum = '0;
        end else if (r_s1_valid && r_s1_add) begin
            n_patch_sum = w_patch_ext[PATCH_W] ? '1 : w_patch_ext[PATCH_W-1:0];
            if (r_s1_center) begin
                n_center_sum = w_center_ext[CENTER_W] ? '1 : w_center_ext[CENTER_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_sum  <= '0;
            r_center_sum <= '0;
        end else begin
            r_patch_sum  <= n_patch_sum;
            r_center_sum <= n_center_sum;
        end
    end

    assign o_status.valid     = r_s1_valid;
    assign o_status.cand_end  = r_s1_cand_end;
    assign o_status.query_end = r_s1_query_end;
    assign o_row              = r_s1_row;
    assign o_col              = r_s1_col;
    assign o_patch_sum        = r_patch_sum;
    assign o_center_sum       = r_center_sum;

endmodule

`default_nettype wire

>>> rtl/wptm_cell.sv
// ============================================================================
// wptm_cell
// One best-match slot: shifts toward the head on readout, passes the
// worst-slot scan toward the tail.
// ============================================================================
`default_nettype none

module wptm_cell #(
    parameter int IDX = 0,
    parameter int IW  = 3,
    parameter int KW  = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire wptm_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic [IW-1:0]                   i_wr_idx,
    input  wire logic [KW-1:0]                   i_k,
    input  wire wptm_pkg::t_slot                 i_next,
    output wptm_pkg::t_slot                      o_slot,
    input  wire logic [IW-1:0]                   i_scan_idx,
    input  wire logic [wptm_pkg::DIST_W-1:0]     i_scan_dist,
    output logic [IW-1:0]                        o_scan_idx,
    output logic [wptm_pkg::DIST_W-1:0]          o_scan_dist
);
    import wptm_pkg::*;

    t_slot              r_slot;
    t_slot              n_slot;
    logic [IW-1:0]      r_scan_idx;
    logic [DIST_W-1:0]  r_scan_dist;
    logic               w_take;

    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.clear) begin
            n_slot = SLOT_EMPTY;
        end else if (i_ctrl.shift) begin
            n_slot = i_next;
        end else if (i_ctrl.write && (i_wr_idx == IW'(IDX))) begin
            n_slot = i_ctrl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_EMPTY;
        end else begin
            r_slot <= n_slot;
        end
    end

    // Take over the running worst only on a strictly larger distance
    assign w_take = (KW'(IDX) < i_k) && (r_slot.distance > i_scan_dist);

    always_ff @(posedge i_clk) begin
        r_scan_idx  <= w_take ? IW'(IDX) : i_scan_idx;
        r_scan_dist <= w_take ? r_slot.distance : i_scan_dist;
    end

    assign o_slot      = r_slot;
    assign o_scan_idx  = r_scan_idx;
    assign o_scan_dist = r_scan_dist;

endmodule

`default_nettype wire

>>> rtl/weighted_patch_topk_matcher.sv
// ============================================================================
// weighted_patch_topk_matcher
// Weighted SAD patch matcher that keeps the best candidates of each query.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall): one item per pixel pair of query
//   and candidate patch, with its ring distance and end-of-candidate and
//   end-of-query flags. Pixel items are taken one per cycle while not stalled.
//   An item that ends a candidate stalls the input while the candidate is
//   judged; if it replaces a slot, the worst-slot scan then walks the whole
//   cell row while the input stays stalled. An item that ends a query
//   produces keep_count result items (clamped to 1..MAX_KEEP) on the output
//   channel (o_out_valid / i_out_stall), slot 0 first, o_last on the final
//   one. Results follow the judging (and the scan when the item also keeps a
//   candidate), one per cycle while i_out_stall is low; the input is stalled
//   until the last result is loaded into the output register.
//   A stalled result holds in the output register; readout of the cell row
//   waits until it is taken.
//   Configuration writes (i_cfg_we) take effect at once; write them while idle.
//   Reset is synchronous and active low: all slots empty at distance 99999,
//   sums zero, registers at their defaults, no result pending.
// ============================================================================
`default_nettype none

module weighted_patch_topk_matcher #(
    parameter int MAX_KEEP    = 8,
    parameter int MAX_RING    = 3,
    parameter int COORD_LIMIT = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [wptm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [wptm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [wptm_pkg::PIX_W-1:0]           i_query_red,
    input  wire logic [wptm_pkg::PIX_W-1:0]           i_query_green,
    input  wire logic [wptm_pkg::PIX_W-1:0]           i_query_blue,
    input  wire logic [wptm_pkg::PIX_W-1:0]           i_cand_red,
    input  wire logic [wptm_pkg::PIX_W-1:0]           i_cand_green,
    input  wire logic [wptm_pkg::PIX_W-1:0]           i_cand_blue,
    input  wire logic [1:0]                           i_ring,
    input  wire logic [wptm_pkg::COORD_W-1:0]         i_cand_row,
    input  wire logic [wptm_pkg::COORD_W-1:0]         i_cand_col,
    input  wire logic                                 i_pixel_valid,
    input  wire logic                                 i_last_of_candidate,
    input  wire logic                                 i_last_of_query,
    // output channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [2:0]                                o_slot_index,
    output logic                                      o_found,
    output logic [wptm_pkg::COORD_W-1:0]              o_match_row,
    output logic [wptm_pkg::COORD_W-1:0]              o_match_col,
    output logic [wptm_pkg::DIST_W-1:0]               o_match_distance,
    output logic                                      o_last
);
    import wptm_pkg::*;

    localparam int KW  = $clog2(MAX_KEEP + 1);
    localparam int IW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int KCW = (KW > 4) ? KW : 4;
    localparam logic [KCW-1:0] KEEP_MAX = KCW'(MAX_KEEP);

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,   // take items, accumulate
        ST_JUDGE = 4'b0010,   // decide on the finished candidate
        ST_SCAN  = 4'b0100,   // worst-slot scan walks the cell row
        ST_EMIT  = 4'b1000    // shift slots out as result items
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CENTER_W-1:0]           r_center_limit;
    logic [3:0]                    r_keep_count;
    logic [3:0][WEIGHT_W-1:0]      r_weights;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_limit <= CENTER_W'(50);
            r_keep_count   <= 4'd1;
            r_weights      <= {4{WEIGHT_W'(1)}};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_LIMIT: r_center_limit <= i_cfg_data[CENTER_W-1:0];
                CFG_KEEP_COUNT:   r_keep_count   <= i_cfg_data[3:0];
                CFG_WEIGHT_RING0: r_weights[0]   <= i_cfg_data;
                CFG_WEIGHT_RING1: r_weights[1]   <= i_cfg_data;
                CFG_WEIGHT_RING2: r_weights[2]   <= i_cfg_data;
                CFG_WEIGHT_RING3: r_weights[3]   <= i_cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Slots in use, clamped to 1..MAX_KEEP
    logic [KCW-1:0] w_keep_ext;
    logic [KCW-1:0] w_k_clamped;
    logic [KW-1:0]  w_k;

    assign w_keep_ext  = KCW'(r_keep_count);
    assign w_k_clamped = (w_keep_ext == '0) ? KCW'(1) :
                         (w_keep_ext > KEEP_MAX) ? KEEP_MAX : w_keep_ext;
    assign w_k         = KW'(w_k_clamped);

    // ------------------------------------------------------------------
    // Front end: differences, weights and the two sums
    // ------------------------------------------------------------------
    t_state                  r_state;
    t_state                  n_state;
    t_acc_status             w_status;
    logic [COORD_W-1:0]      w_row;
    logic [COORD_W-1:0]      w_col;
    logic [PATCH_W-1:0]      w_patch_sum;
    logic [CENTER_W-1:0]     w_center_sum;
    logic                    w_in_fire;
    logic                    w_end_pending;

    // An item that ends a candidate or query blocks the next one until judged
    assign w_end_pending = w_status.valid && (w_status.cand_end || w_status.query_end);
    assign o_in_stall    = (r_state != ST_RUN) || w_end_pending;
    assign w_in_fire     = i_in_valid && !o_in_stall;

    wptm_acc #(
        .MAX_RING    (MAX_RING),
        .COORD_LIMIT (COORD_LIMIT)
    ) u_acc (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (w_in_fire),
        .i_query_red         (i_query_red),
        .i_query_green       (i_query_green),
        .i_query_blue        (i_query_blue),
        .i_cand_red          (i_cand_red),
        .i_cand_green        (i_cand_green),
        .i_cand_blue         (i_cand_blue),
        .i_ring              (i_ring),
        .i_cand_row          (i_cand_row),
        .i_cand_col          (i_cand_col),
        .i_pixel_valid       (i_pixel_valid),
        .i_last_of_candidate (i_last_of_candidate),
        .i_last_of_query     (i_last_of_query),
        .i_weights           (r_weights),
        .i_clear_sums        (r_state == ST_JUDGE),
        .o_status            (w_status),
        .o_row               (w_row),
        .o_col               (w_col),
        .o_patch_sum         (w_patch_sum),
        .o_center_sum        (w_center_sum)
    );

    // ------------------------------------------------------------------
    // Row of slot cells
    // ------------------------------------------------------------------
    t_cell_ctrl          w_ctrl;
    logic [IW-1:0]       w_wr_idx;
    t_slot               w_slot      [MAX_KEEP];
    t_slot               w_next      [MAX_KEEP];
    logic [IW-1:0]       w_scan_in_idx  [MAX_KEEP];
    logic [DIST_W-1:0]   w_scan_in_dist [MAX_KEEP];
    logic [IW-1:0]       w_scan_idx     [MAX_KEEP];
    logic [DIST_W-1:0]   w_scan_dist    [MAX_KEEP];

    logic [IW-1:0]       r_seed_idx;
    logic [DIST_W-1:0]   r_seed_dist;

    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        if (g == MAX_KEEP - 1) begin : g_tail
            assign w_next[g] = SLOT_EMPTY;
        end else begin : g_link
            assign w_next[g] = w_slot[g+1];
        end

        if (g == 0) begin : g_head
            assign w_scan_in_idx[g]  = r_seed_idx;
            assign w_scan_in_dist[g] = r_seed_dist;
        end else begin : g_pass
            assign w_scan_in_idx[g]  = w_scan_idx[g-1];
            assign w_scan_in_dist[g] = w_scan_dist[g-1];
        end

        wptm_cell #(
            .IDX (g),
            .IW  (IW),
            .KW  (KW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_wr_idx    (w_wr_idx),
            .i_k         (w_k),
            .i_next      (w_next[g]),
            .o_slot      (w_slot[g]),
            .i_scan_idx  (w_scan_in_idx[g]),
            .i_scan_dist (w_scan_in_dist[g]),
            .o_scan_idx  (w_scan_idx[g]),
            .o_scan_dist (w_scan_dist[g])
        );
    end

    // ------------------------------------------------------------------
    // Control: judge, scan, readout
    // ------------------------------------------------------------------
    logic [IW-1:0]       r_worst;
    logic [DIST_W-1:0]   r_worst_dist;     // mirrors the worst slot's distance
    logic [KW-1:0]       r_cnt;
    logic                r_out_valid;
    logic [2:0]          r_out_slot;
    t_slot               r_out_data;
    logic                r_out_last;

    logic [IW-1:0]       n_worst;
    logic [DIST_W-1:0]   n_worst_dist;
    logic [KW-1:0]       n_cnt;
    logic                n_out_valid;
    logic                n_seed_load;

    logic                w_stale;
    logic [IW-1:0]       w_sel;
    logic [DIST_W-1:0]   w_sel_dist;
    logic                w_keep;
    logic                w_emit_fire;
    logic                w_emit_last;

    // A worst slot outside the slots in use falls back to slot 0
    assign w_stale    = !(KW'(r_worst) < w_k);
    assign w_sel      = w_stale ? '0 : r_worst;
    assign w_sel_dist = w_stale ? w_slot[0].distance : r_worst_dist;
    assign w_keep     = w_status.cand_end
                     && (w_center_sum < r_center_limit)
                     && (w_patch_sum < PATCH_W'(w_sel_dist));

    assign w_emit_fire = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_emit_last = ((r_cnt + KW'(1)) == w_k);

    always_comb begin
        n_state       = r_state;
        n_worst       = r_worst;
        n_worst_dist  = r_worst_dist;
        n_cnt         = r_cnt;
        n_seed_load   = 1'b0;
        w_ctrl.write  = 1'b0;
        w_ctrl.shift  = 1'b0;
        w_ctrl.clear  = 1'b0;
        w_ctrl.data   = '{filled: 1'b1, row: w_row, col: w_col,
                          distance: w_patch_sum[DIST_W-1:0]};
        w_wr_idx      = w_sel;
        n_out_valid   = r_out_valid && i_out_stall;

        case (r_state)
            ST_RUN: begin
                if (w_end_pending) begin
                    n_state = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                n_cnt = '0;
                if (w_keep) begin
                    // write the new candidate, then rescan for the worst slot
                    w_ctrl.write = 1'b1;
                    n_seed_load  = 1'b1;
                    n_state      = ST_SCAN;
                end else begin
                    if (w_status.cand_end) begin
                        n_worst      = w_sel;
                        n_worst_dist = w_sel_dist;
                    end
                    n_state = w_status.query_end ? ST_EMIT : ST_RUN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + KW'(1);
                if (r_cnt == KW'(MAX_KEEP)) begin
                    n_worst      = w_scan_idx[MAX_KEEP-1];
                    n_worst_dist = w_scan_dist[MAX_KEEP-1];
                    n_cnt        = '0;
                    n_state      = w_status.query_end ? ST_EMIT : ST_RUN;
                end
            end
            ST_EMIT: begin
                if (w_emit_fire) begin
                    n_out_valid = 1'b1;
                    if (w_emit_last) begin
                        // empty every slot after the last one is out
                        w_ctrl.clear = 1'b1;
                        n_worst      = '0;
                        n_worst_dist = EMPTY_DIST;
                        n_cnt        = '0;
                        n_state      = ST_RUN;
                    end else begin
                        w_ctrl.shift = 1'b1;
                        n_cnt        = r_cnt + KW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_worst      <= '0;
            r_worst_dist <= EMPTY_DIST;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_worst      <= n_worst;
            r_worst_dist <= n_worst_dist;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // Scan seed: the slot just written and its new distance
    always_ff @(posedge i_clk) begin
        if (n_seed_load) begin
            r_seed_idx  <= w_sel;
            r_seed_dist <= w_patch_sum[DIST_W-1:0];
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_out_slot <= 3'(r_cnt);
            r_out_data <= w_slot[0];
            r_out_last <= w_emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_slot_index     = r_out_slot;
    assign o_found          = r_out_data.filled;
    assign o_match_row      = r_out_data.row;
    assign o_match_col      = r_out_data.col;
    assign o_match_distance = r_out_data.distance;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire
